// ===== hdl/vna_pkg.sv =====
// Shared types and constants for the vertex normal accumulator.
// No dependencies.
package vna_pkg;
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_FACE = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_LOAD = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  localparam int PosW = 24;
  localparam int NrmW = 48;
  localparam int IdxW = 12;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic signed [NrmW-1:0] nrm_t;
  typedef logic [IdxW-1:0]        idx_t;

  localparam logic signed [NrmW-1:0] AccMax = {1'b0, {(NrmW-1){1'b1}}};
  localparam logic signed [NrmW-1:0] AccMin = {1'b1, {(NrmW-1){1'b0}}};

  // Saturating 48-bit add.
  function automatic nrm_t sat_add(nrm_t a, nrm_t b);
    logic signed [NrmW:0] s;
    s = {a[NrmW-1], a} + {b[NrmW-1], b};
    if (s[NrmW] != s[NrmW-1]) begin
      sat_add = s[NrmW] ? AccMin : AccMax;
    end else begin
      sat_add = s[NrmW-1:0];
    end
  endfunction
endpackage

// ===== hdl/vna_mac.sv =====
// Shared multiply-subtract unit for the cross product terms.
// Depends on vna_pkg.
module vna_mac (
  input  logic                    clk_i,
  input  logic                    start_i,
  input  logic                    second_i,
  input  logic signed [24:0]      a_i,
  input  logic signed [24:0]      b_i,
  output logic signed [50:0]      res_o
);
  import vna_pkg::*;
  logic signed [49:0] prod;
  logic signed [50:0] acc_q, acc_d;
  // Product registered, then subtracted from the first term.
  logic signed [49:0] prod_q;
  assign prod = a_i * b_i;
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    acc_q  <= acc_d;
  end
  always_comb begin
    acc_d = acc_q;
    if (start_i) acc_d = 51'(prod_q);
    else if (second_i) acc_d = acc_q - 51'(prod_q);
  end
  assign res_o = acc_q;
endmodule

// ===== hdl/vertex_normal_accumulator.sv =====
// Vertex normal accumulator: position and normal stores under a small sequencer.
// Load, read miss, skipped face or unused action go straight to S_OUT; a read passes
// S_RDN and S_RDW; a face takes 4 position reads, 8 steps of the shared multiplier and
// one read-modify-write pair per corner; no request is taken while a result waits.
// Async reset (rst_ni low) clears count and control; memories are not cleared.
// Depends on vna_pkg and vna_mac.
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  vna_pkg::idx_t        read_index_i,
  input  vna_pkg::pos_t        pos_x_i,
  input  vna_pkg::pos_t        pos_y_i,
  input  vna_pkg::pos_t        pos_z_i,
  input  vna_pkg::idx_t        corner_a_i,
  input  vna_pkg::idx_t        corner_b_i,
  input  vna_pkg::idx_t        corner_c_i,
  input  vna_pkg::idx_t        corner_d_i,
  input  logic                 is_quad_i,
  input  logic                 face_has_normal_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vna_pkg::nrm_t        normal_x_o,
  output vna_pkg::nrm_t        normal_y_o,
  output vna_pkg::nrm_t        normal_z_o,
  output logic [1:0]           status_o
);
  import vna_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PRD   = 8'b0000_0010, // read positions of corners
    S_MUL   = 8'b0000_0100, // cross product terms
    S_NRD   = 8'b0000_1000, // read normal of a corner
    S_NWR   = 8'b0001_0000, // write back saturated sum
    S_RDN   = 8'b0010_0000, // read request: normal data captured
    S_OUT   = 8'b0100_0000,
    S_RDW   = 8'b1000_0000  // read request: wait before result
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q;

  // Request registers
  idx_t       c_q [4];
  logic       quad_q;
  logic [1:0] step_q;  // corner / position index
  logic [2:0] mstep_q; // multiplier step

  // Memories
  logic [3*PosW-1:0] pmem [MAX_VERTICES];
  logic [3*NrmW-1:0] nmem [MAX_VERTICES];
  logic [3*PosW-1:0] prd_q;
  logic [3*NrmW-1:0] nrd_q;
  logic              p_we, n_we;
  logic [AW-1:0]     p_addr, n_addr;
  logic [3*PosW-1:0] p_wd;
  logic [3*NrmW-1:0] n_wd;

  always_ff @(posedge clk_i) begin
    if (p_we) pmem[p_addr] <= p_wd;
    prd_q <= pmem[p_addr];
  end
  always_ff @(posedge clk_i) begin
    if (n_we) nmem[n_addr] <= n_wd;
    nrd_q <= nmem[n_addr];
  end

  // Positions of P0..P2, edge vectors
  pos_t p_q [3][3];
  logic signed [PosW:0] u [3];
  logic signed [PosW:0] v [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u[k] = {p_q[1][k][PosW-1], p_q[1][k]} - {p_q[0][k][PosW-1], p_q[0][k]};
      v[k] = {p_q[2][k][PosW-1], p_q[2][k]} - {p_q[1][k][PosW-1], p_q[1][k]};
    end
  end

  // Multiplier schedule: step 2n: ua*vb, step 2n+1: ub*va.
  logic signed [PosW:0] ma, mb;
  logic                 m_start, m_second;
  logic signed [50:0]   m_res;
  nrm_t                 f_q [3];
  always_comb begin
    ma = u[1]; mb = v[2];
    case (mstep_q)
      3'd0: begin ma = u[1]; mb = v[2]; end
      3'd1: begin ma = u[2]; mb = v[1]; end
      3'd2: begin ma = u[2]; mb = v[0]; end
      3'd3: begin ma = u[0]; mb = v[2]; end
      3'd4: begin ma = u[0]; mb = v[1]; end
      3'd5: begin ma = u[1]; mb = v[0]; end
      default: begin ma = u[1]; mb = v[2]; end
    endcase
  end
  // The product of each step passes through prod_q and then into acc_q in vna_mac.
  logic [2:0] pstep;
  assign pstep    = mstep_q - 3'd1;
  assign m_start  = (state_q == S_MUL) && (mstep_q != 3'd0) && !pstep[0];
  assign m_second = (state_q == S_MUL) && (mstep_q != 3'd0) && pstep[0];

  vna_mac u_mac (
    .clk_i   (clk_i),
    .start_i (m_start),
    .second_i(m_second),
    .a_i     (ma),
    .b_i     (mb),
    .res_o   (m_res)
  );

  // Result register
  logic       ovalid_q;
  nrm_t       on_q [3];
  logic [1:0] ost_q;

  logic valid_face;
  logic [CW-1:0] cnt_ext;
  assign cnt_ext = count_q;
  always_comb begin
    valid_face = ({1'b0, corner_a_i} < {1'b0, cnt_ext}) &&
                 ({1'b0, corner_b_i} < {1'b0, cnt_ext}) &&
                 ({1'b0, corner_c_i} < {1'b0, cnt_ext}) &&
                 (!is_quad_i || ({1'b0, corner_d_i} < {1'b0, cnt_ext}));
  end

  logic accept;
  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign accept = in_valid_i && in_ready_o;

  idx_t cur_c;
  assign cur_c = c_q[step_q];

  always_comb begin
    p_we = 1'b0; p_addr = AW'(c_q[step_q]); p_wd = {pos_x_i, pos_y_i, pos_z_i};
    n_we = 1'b0; n_addr = AW'(cur_c); n_wd = '0;
    if (state_q == S_IDLE) begin
      p_addr = AW'(count_q);
      n_addr = (action_i == ACT_READ) ? AW'(read_index_i) : AW'(count_q);
      if (accept && action_i == ACT_LOAD && count_q < CW'(MAX_VERTICES)) begin
        p_we = 1'b1; n_we = 1'b1;
      end
    end
    if (state_q == S_NWR) begin
      n_we = 1'b1;
      n_wd = {sat_add(nrd_q[3*NrmW-1:2*NrmW], f_q[0]),
              sat_add(nrd_q[2*NrmW-1:NrmW], f_q[1]),
              sat_add(nrd_q[NrmW-1:0], f_q[2])};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) begin
        state_d = S_OUT;
        if (action_i == ACT_FACE && valid_face && !face_has_normal_i) state_d = S_PRD;
        if (action_i == ACT_READ && {1'b0, read_index_i} < {1'b0, cnt_ext}) state_d = S_RDN;
      end
      S_PRD: if (step_q == 2'd3) state_d = S_MUL;
      S_MUL: if (mstep_q == 3'd7) state_d = S_NRD;
      S_NRD: state_d = S_NWR;
      S_NWR: state_d = ((step_q == 2'd2 && !quad_q) || step_q == 2'd3) ? S_OUT : S_NRD;
      S_RDN: state_d = S_RDW;
      S_RDW: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      step_q   <= '0;
      mstep_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      if (state_q == S_OUT) ovalid_q <= 1'b1;
      if (p_we && state_q == S_IDLE) count_q <= count_q + CW'(1);
      case (state_q)
        S_IDLE:  begin step_q <= '0; mstep_q <= '0; end
        S_PRD:   step_q <= step_q + 2'd1;
        S_MUL:   begin mstep_q <= mstep_q + 3'd1; step_q <= '0; end
        S_NWR:   step_q <= step_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q[0] <= corner_a_i; c_q[1] <= corner_b_i;
      c_q[2] <= corner_c_i; c_q[3] <= corner_d_i;
      quad_q <= is_quad_i;
      for (int k = 0; k < 3; k++) on_q[k] <= '0;
      ost_q <= ST_OK;
      if (action_i == ACT_LOAD && count_q >= CW'(MAX_VERTICES)) ost_q <= ST_FULL;
      if (action_i == ACT_FACE && !valid_face) ost_q <= ST_NOT_LOAD;
      if (action_i == ACT_READ && !({1'b0, read_index_i} < {1'b0, cnt_ext}))
        ost_q <= ST_NOT_LOAD;
    end
    if (state_q == S_PRD && step_q != 2'd0) begin
      p_q[step_q-2'd1][0] <= prd_q[3*PosW-1:2*PosW];
      p_q[step_q-2'd1][1] <= prd_q[2*PosW-1:PosW];
      p_q[step_q-2'd1][2] <= prd_q[PosW-1:0];
    end
    // Results complete at step 3, 5, 7 (after second subtract).
    if (state_q == S_MUL && (mstep_q == 3'd3 || mstep_q == 3'd5 || mstep_q == 3'd7)) begin
      f_q[mstep_q[2:1]-2'd1] <= nrm_t'(m_res >>> 12);
    end
    // Normal read issued at accept is in nrd_q during the first read state.
    if (state_q == S_RDN) begin
      on_q[0] <= nrd_q[3*NrmW-1:2*NrmW];
      on_q[1] <= nrd_q[2*NrmW-1:NrmW];
      on_q[2] <= nrd_q[NrmW-1:0];
    end
  end

  assign out_valid_o = ovalid_q;
  assign normal_x_o  = on_q[0];
  assign normal_y_o  = on_q[1];
  assign normal_z_o  = on_q[2];
  assign status_o    = ost_q;
endmodule

// ===== hdl/vna_checker.sv =====
// Port-level checks for the vertex normal accumulator.
// Depends on vna_pkg and vertex_normal_accumulator (bound below).
module vna_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o
);
  import vna_pkg::*;
  a_no_ready_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready with pending result");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != ST_RSVD) else $error("illegal status");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .status_o(status_o)
);
